// ===== hw/rtl/nbga_pkg.sv =====
// Shared types, constants and a helper function for the n-body gravity unit.
// No dependencies; every other file takes names from here by scope.
package nbga_pkg;

    localparam int MAX_BODIES = 64;
    localparam int IDX_W      = $clog2(MAX_BODIES);
    localparam int CNT_W      = $clog2(MAX_BODIES + 1);

    localparam int COORD_W = 32;
    localparam int MAG_W   = COORD_W + 1;
    localparam int R_W     = 51;
    localparam int S_W     = 32;
    localparam int DEN_W   = 83;
    localparam int NUM_W   = 64;
    localparam int MULA_W  = 64;
    localparam int PROD_W  = MULA_W + MAG_W;
    localparam int DIVN_W  = PROD_W + 6;
    localparam int QUO_W   = 57;
    localparam int SQV_W   = 63;
    localparam int ACC_W   = 64;
    localparam int OUT_W   = 48;

    localparam logic [31:0] GRAV_RESET = 32'd65536;
    localparam logic [31:0] SOFT_RESET = 32'd655;
    localparam logic [QUO_W-1:0] TERM_CAP = QUO_W'(57'h100000000000000);

    // configuration register indexes
    localparam logic CFG_GRAV = 1'b0;
    localparam logic CFG_SOFT = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD_I,
        OP_LOAD_J,
        OP_SQ,
        OP_SQRT,
        OP_MUL_D,
        OP_MUL_N,
        OP_MUL_P,
        OP_DIV
    } t_op;

    typedef struct packed {
        logic             start;
        t_op              op;
        logic [1:0]       axis;
        logic             wr_en;
        logic             rd_en;
        logic [IDX_W-1:0] addr;
    } t_dp_cmd;

    typedef struct packed {
        logic       done;
        logic       den_zero;
        logic [2:0] mag_zero;
    } t_dp_sts;

    // clamp a signed sum into the output range
    function automatic logic [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
        lo = -(ACC_W'(64'sd1 <<< (OUT_W - 1)));
        if (v > hi)
            sat_out = hi[OUT_W-1:0];
        else if (v < lo)
            sat_out = lo[OUT_W-1:0];
        else
            sat_out = v[OUT_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/nbga_if.sv =====
// Channel interfaces for body input and acceleration output.
// Depends on nbga_pkg for the index width.
interface nbga_body_if;
    logic        valid;
    logic        ready;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] body_mass;
    logic        last_body;

    modport source (output valid, pos_x, pos_y, pos_z, body_mass, last_body, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, body_mass, last_body, output ready);
endinterface

interface nbga_acc_if;
    logic                       valid;
    logic                       ready;
    logic [47:0]                acc_x;
    logic [47:0]                acc_y;
    logic [47:0]                acc_z;
    logic [nbga_pkg::IDX_W-1:0] body_index;
    logic                       last_result;

    modport source (output valid, acc_x, acc_y, acc_z, body_index, last_result, input ready);
    modport sink   (input valid, acc_x, acc_y, acc_z, body_index, last_result, output ready);
endinterface

// ===== hw/rtl/nbody_gravity_acceleration_unit.sv =====
// Top level of the direct-summation n-body gravity unit.
// Depends on nbga_pkg, nbga_if, nbga_ctrl and nbga_datapath.
//
//   port      dir  kind         contents
//   i_body    in   valid/ready  pos_x, pos_y, pos_z, body_mass, last_body
//   o_acc     out  valid/ready  acc_x, acc_y, acc_z, body_index, last_result
//   i_cfg_*   in   write only   index 0 grav_constant, index 1 softening
//
// A body that is not marked last is written to the store as it is accepted, while
// the store has room. The marked body starts N*N pair evaluations on one shared
// shift-add multiplier, a two-bit-per-step square root and a one-bit-per-cycle
// divider; a pair's time is set mainly by up to three 103-step divisions, which
// the self pair skips. The store is not cleared at reset.
// While a result waits on o_acc the computation and the input side stall.
module nbody_gravity_acceleration_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    nbga_body_if.sink          i_body,
    nbga_acc_if.source         o_acc,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);

    nbga_pkg::t_dp_cmd cmd;
    nbga_pkg::t_dp_sts sts;

    // sequencer
    nbga_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_body.valid),
        .i_in_last   (i_body.last_body),
        .o_in_ready  (i_body.ready),
        .o_out_valid (o_acc.valid),
        .i_out_ready (o_acc.ready),
        .o_out_index (o_acc.body_index),
        .o_out_last  (o_acc.last_result),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // arithmetic and storage
    nbga_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_pos_x     (i_body.pos_x),
        .i_pos_y     (i_body.pos_y),
        .i_pos_z     (i_body.pos_z),
        .i_body_mass (i_body.body_mass),
        .o_acc_x     (o_acc.acc_x),
        .o_acc_y     (o_acc.acc_y),
        .o_acc_z     (o_acc.acc_z)
    );

endmodule

// ===== hw/rtl/nbga_datapath.sv =====
// Datapath: body store, config registers, shared shift-add multiplier,
// bit-pair square root, restoring divider and acceleration accumulators.
// Depends on nbga_pkg.
module nbga_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  nbga_pkg::t_dp_cmd             i_cmd,
    output nbga_pkg::t_dp_sts             o_sts,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [31:0]                   i_cfg_data,
    input  logic [31:0]                   i_pos_x,
    input  logic [31:0]                   i_pos_y,
    input  logic [31:0]                   i_pos_z,
    input  logic [31:0]                   i_body_mass,
    output logic [nbga_pkg::OUT_W-1:0]    o_acc_x,
    output logic [nbga_pkg::OUT_W-1:0]    o_acc_y,
    output logic [nbga_pkg::OUT_W-1:0]    o_acc_z
);

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] m;
    } t_body;

    t_body r_mem [nbga_pkg::MAX_BODIES];
    t_body r_rdata;

    logic [31:0] r_grav;
    logic [31:0] r_soft;

    logic [31:0]                     r_pi [3];
    logic [nbga_pkg::MAG_W-1:0]      r_mag [3];
    logic [2:0]                      r_neg;
    logic [31:0]                     r_mass_j;
    logic [nbga_pkg::R_W-1:0]        r_r;
    logic [nbga_pkg::S_W-1:0]        r_s;
    logic [nbga_pkg::DEN_W-1:0]      r_d;
    logic [nbga_pkg::NUM_W-1:0]      r_n;
    logic signed [nbga_pkg::ACC_W-1:0] r_acc [3];

    logic [nbga_pkg::PROD_W-1:0]     r_ma;
    logic [nbga_pkg::MAG_W-1:0]      r_mb;
    logic [nbga_pkg::PROD_W-1:0]     r_mp;

    logic [nbga_pkg::SQV_W-1:0]      r_sv;
    logic [nbga_pkg::SQV_W-1:0]      r_sres;
    logic [nbga_pkg::SQV_W-1:0]      r_sbit;

    logic [nbga_pkg::DIVN_W-1:0]     r_num;
    logic [nbga_pkg::DEN_W-1:0]      r_rem;
    logic [nbga_pkg::QUO_W-1:0]      r_quo;
    logic                            r_qbig;
    logic [6:0]                      r_dcnt;

    logic                            r_busy;
    nbga_pkg::t_op                   r_op;
    logic [1:0]                      r_axis;

    logic                            mul_op;
    logic                            fin;
    logic [nbga_pkg::SQV_W:0]        sq_try;
    logic [nbga_pkg::DEN_W:0]        div_try;
    logic                            div_ge;
    logic [nbga_pkg::QUO_W-1:0]      quo_fin;
    logic [nbga_pkg::MAG_W-1:0]      dsub [3];
    logic [31:0]                     pj [3];

    assign pj[0] = r_rdata.x;
    assign pj[1] = r_rdata.y;
    assign pj[2] = r_rdata.z;

    // signed coordinate differences, one bit wider than the operands
    always_comb begin
        for (int k = 0; k < 3; k++)
            dsub[k] = {pj[k][31], pj[k]} - {r_pi[k][31], r_pi[k]};
    end

    assign mul_op = (r_op == nbga_pkg::OP_SQ) || (r_op == nbga_pkg::OP_MUL_D)
                 || (r_op == nbga_pkg::OP_MUL_N) || (r_op == nbga_pkg::OP_MUL_P);

    assign fin = r_busy && ((mul_op && (r_mb == '0))
                 || ((r_op == nbga_pkg::OP_SQRT) && (r_sbit == '0))
                 || ((r_op == nbga_pkg::OP_DIV) && (r_dcnt == '0)));

    assign sq_try  = {1'b0, r_sres} + {1'b0, r_sbit};
    assign div_try = {r_rem, r_num[nbga_pkg::DIVN_W-1]};
    assign div_ge  = div_try >= {1'b0, r_d};
    assign quo_fin = (r_qbig || (r_quo > nbga_pkg::TERM_CAP)) ? nbga_pkg::TERM_CAP : r_quo;

    assign o_sts.done        = fin;
    assign o_sts.den_zero    = (r_d == '0);
    assign o_sts.mag_zero[0] = (r_mag[0] == '0);
    assign o_sts.mag_zero[1] = (r_mag[1] == '0);
    assign o_sts.mag_zero[2] = (r_mag[2] == '0);

    assign o_acc_x = nbga_pkg::sat_out(r_acc[0]);
    assign o_acc_y = nbga_pkg::sat_out(r_acc[1]);
    assign o_acc_z = nbga_pkg::sat_out(r_acc[2]);

    // body store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en)
            r_mem[i_cmd.addr] <= {i_pos_x, i_pos_y, i_pos_z, i_body_mass};
        if (i_cmd.rd_en)
            r_rdata <= r_mem[i_cmd.addr];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav <= nbga_pkg::GRAV_RESET;
            r_soft <= nbga_pkg::SOFT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == nbga_pkg::CFG_GRAV)
                r_grav <= i_cfg_data;
            else
                r_soft <= i_cfg_data;
        end
    end

    // operation control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_op   <= nbga_pkg::OP_NONE;
            r_axis <= '0;
        end else if (i_cmd.start && !r_busy) begin
            r_op   <= i_cmd.op;
            r_axis <= i_cmd.axis;
            r_busy <= (i_cmd.op != nbga_pkg::OP_LOAD_I) && (i_cmd.op != nbga_pkg::OP_LOAD_J)
                   && (i_cmd.op != nbga_pkg::OP_NONE);
        end else if (fin) begin
            r_busy <= 1'b0;
        end
    end

    // arithmetic units and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start && !r_busy) begin
            case (i_cmd.op)
                nbga_pkg::OP_LOAD_I: begin
                    r_pi[0] <= r_rdata.x;
                    r_pi[1] <= r_rdata.y;
                    r_pi[2] <= r_rdata.z;
                    for (int k = 0; k < 3; k++)
                        r_acc[k] <= '0;
                end
                nbga_pkg::OP_LOAD_J: begin
                    for (int k = 0; k < 3; k++) begin
                        r_neg[k] <= dsub[k][nbga_pkg::MAG_W-1];
                        r_mag[k] <= dsub[k][nbga_pkg::MAG_W-1] ? -dsub[k] : dsub[k];
                    end
                    r_mass_j <= r_rdata.m;
                    r_r      <= nbga_pkg::R_W'(r_soft);
                end
                nbga_pkg::OP_SQ: begin
                    r_ma <= nbga_pkg::PROD_W'(r_mag[i_cmd.axis]);
                    r_mb <= r_mag[i_cmd.axis];
                    r_mp <= '0;
                end
                nbga_pkg::OP_MUL_D: begin
                    r_ma <= nbga_pkg::PROD_W'(r_r);
                    r_mb <= nbga_pkg::MAG_W'(r_s);
                    r_mp <= '0;
                end
                nbga_pkg::OP_MUL_N: begin
                    r_ma <= nbga_pkg::PROD_W'(r_grav);
                    r_mb <= nbga_pkg::MAG_W'(r_mass_j);
                    r_mp <= '0;
                end
                nbga_pkg::OP_MUL_P: begin
                    r_ma <= nbga_pkg::PROD_W'(r_n);
                    r_mb <= r_mag[i_cmd.axis];
                    r_mp <= '0;
                end
                nbga_pkg::OP_SQRT: begin
                    r_sv   <= {r_r, 12'b0};
                    r_sres <= '0;
                    r_sbit <= nbga_pkg::SQV_W'(63'h4000000000000000);
                end
                nbga_pkg::OP_DIV: begin
                    r_num  <= {r_mp, 6'b0};
                    r_rem  <= '0;
                    r_quo  <= '0;
                    r_qbig <= 1'b0;
                    r_dcnt <= 7'(nbga_pkg::DIVN_W);
                end
                default: ;
            endcase
        end else if (fin) begin
            // retire the running operation
            case (r_op)
                nbga_pkg::OP_SQ:    r_r <= r_r + nbga_pkg::R_W'(r_mp >> 16);
                nbga_pkg::OP_SQRT:  r_s <= r_sres[nbga_pkg::S_W-1:0];
                nbga_pkg::OP_MUL_D: r_d <= r_mp[nbga_pkg::DEN_W-1:0];
                nbga_pkg::OP_MUL_N: r_n <= r_mp[nbga_pkg::NUM_W-1:0];
                nbga_pkg::OP_DIV: begin
                    if (r_neg[r_axis])
                        r_acc[r_axis] <= r_acc[r_axis] - nbga_pkg::ACC_W'(quo_fin);
                    else
                        r_acc[r_axis] <= r_acc[r_axis] + nbga_pkg::ACC_W'(quo_fin);
                end
                default: ;
            endcase
        end else if (r_busy) begin
            // advance one step of the running operation
            if (mul_op) begin
                if (r_mb[0])
                    r_mp <= r_mp + r_ma;
                r_ma <= r_ma << 1;
                r_mb <= r_mb >> 1;
            end else if (r_op == nbga_pkg::OP_SQRT) begin
                if ({1'b0, r_sv} >= sq_try) begin
                    r_sv   <= r_sv - sq_try[nbga_pkg::SQV_W-1:0];
                    r_sres <= (r_sres >> 1) + r_sbit;
                end else begin
                    r_sres <= r_sres >> 1;
                end
                r_sbit <= r_sbit >> 2;
            end else if (r_op == nbga_pkg::OP_DIV) begin
                r_num  <= r_num << 1;
                r_rem  <= div_ge ? nbga_pkg::DEN_W'(div_try - {1'b0, r_d})
                                 : div_try[nbga_pkg::DEN_W-1:0];
                r_qbig <= r_qbig | r_quo[nbga_pkg::QUO_W-1];
                r_quo  <= {r_quo[nbga_pkg::QUO_W-2:0], div_ge};
                r_dcnt <= r_dcnt - 7'd1;
            end
        end
    end

endmodule

// ===== hw/rtl/nbga_ctrl.sv =====
// Controller: loads bodies, walks all pairs and sequences the datapath.
// Depends on nbga_pkg.
module nbga_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_last,
    output logic                          o_in_ready,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [nbga_pkg::IDX_W-1:0]    o_out_index,
    output logic                          o_out_last,
    output nbga_pkg::t_dp_cmd             o_cmd,
    input  nbga_pkg::t_dp_sts             i_sts
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_I,
        S_LD_I,
        S_RD_J,
        S_LD_J,
        S_SQ,
        S_SQRT,
        S_MUL_D,
        S_MUL_N,
        S_TERM_MUL,
        S_TERM_DIV,
        S_NEXT_J,
        S_OUT
    } t_state;

    t_state                      r_state;
    logic [nbga_pkg::CNT_W-1:0]  r_cnt;
    logic [nbga_pkg::CNT_W-1:0]  r_n;
    logic [nbga_pkg::IDX_W-1:0]  r_i;
    logic [nbga_pkg::IDX_W-1:0]  r_j;
    logic [1:0]                  r_axis;
    logic                        r_wait;

    logic accept;
    logic store_ok;
    logic compute;
    logic last_i;
    logic last_j;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign store_ok    = r_cnt < nbga_pkg::CNT_W'(nbga_pkg::MAX_BODIES);
    assign last_i      = (nbga_pkg::CNT_W'(r_i) == r_n - 1'b1);
    assign last_j      = (nbga_pkg::CNT_W'(r_j) == r_n - 1'b1);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_index = r_i;
    assign o_out_last  = last_i;

    assign compute = (r_state == S_SQ) || (r_state == S_SQRT) || (r_state == S_MUL_D)
                  || (r_state == S_MUL_N) || (r_state == S_TERM_DIV)
                  || ((r_state == S_TERM_MUL) && !i_sts.mag_zero[r_axis]);

    // datapath command decode
    always_comb begin
        o_cmd.start = 1'b0;
        o_cmd.op    = nbga_pkg::OP_NONE;
        o_cmd.axis  = r_axis;
        o_cmd.wr_en = accept && store_ok;
        o_cmd.rd_en = (r_state == S_RD_I) || (r_state == S_RD_J);
        o_cmd.addr  = r_cnt[nbga_pkg::IDX_W-1:0];
        case (r_state)
            S_RD_I:     o_cmd.addr = r_i;
            S_RD_J:     o_cmd.addr = r_j;
            S_LD_I:     o_cmd.op   = nbga_pkg::OP_LOAD_I;
            S_LD_J:     o_cmd.op   = nbga_pkg::OP_LOAD_J;
            S_SQ:       o_cmd.op   = nbga_pkg::OP_SQ;
            S_SQRT:     o_cmd.op   = nbga_pkg::OP_SQRT;
            S_MUL_D:    o_cmd.op   = nbga_pkg::OP_MUL_D;
            S_MUL_N:    o_cmd.op   = nbga_pkg::OP_MUL_N;
            S_TERM_MUL: o_cmd.op   = nbga_pkg::OP_MUL_P;
            S_TERM_DIV: o_cmd.op   = nbga_pkg::OP_DIV;
            default:    ;
        endcase
        if ((r_state == S_LD_I) || (r_state == S_LD_J))
            o_cmd.start = 1'b1;
        else if (compute)
            o_cmd.start = !r_wait;
    end

    // sequencer state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_n     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_axis  <= '0;
            r_wait  <= 1'b0;
        end else begin
            // hold off a second start until the running op retires
            if (compute && !r_wait)
                r_wait <= 1'b1;
            else if (i_sts.done)
                r_wait <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_in_last) begin
                            r_n     <= store_ok ? r_cnt + 1'b1 : r_cnt;
                            r_cnt   <= '0;
                            r_i     <= '0;
                            r_state <= S_RD_I;
                        end else if (store_ok) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                S_RD_I: r_state <= S_LD_I;
                S_LD_I: begin
                    r_j     <= '0;
                    r_state <= S_RD_J;
                end
                S_RD_J: r_state <= S_LD_J;
                S_LD_J: begin
                    r_axis  <= '0;
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    if (i_sts.done) begin
                        if (r_axis == 2'd2)
                            r_state <= S_SQRT;
                        else
                            r_axis <= r_axis + 2'd1;
                    end
                end
                S_SQRT:  if (i_sts.done) r_state <= S_MUL_D;
                S_MUL_D: if (i_sts.done) r_state <= S_MUL_N;
                S_MUL_N: begin
                    if (i_sts.done) begin
                        r_axis  <= '0;
                        r_state <= i_sts.den_zero ? S_NEXT_J : S_TERM_MUL;
                    end
                end
                S_TERM_MUL: begin
                    // skip an axis with zero offset
                    if (i_sts.mag_zero[r_axis]) begin
                        if (r_axis == 2'd2)
                            r_state <= S_NEXT_J;
                        else
                            r_axis <= r_axis + 2'd1;
                    end else if (i_sts.done) begin
                        r_state <= S_TERM_DIV;
                    end
                end
                S_TERM_DIV: begin
                    if (i_sts.done) begin
                        if (r_axis == 2'd2) begin
                            r_state <= S_NEXT_J;
                        end else begin
                            r_axis  <= r_axis + 2'd1;
                            r_state <= S_TERM_MUL;
                        end
                    end
                end
                S_NEXT_J: begin
                    if (last_j) begin
                        r_state <= S_OUT;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_RD_J;
                    end
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        if (last_i) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_RD_I;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
